@@ design/tgr_pkg.sv @@
// Package for the text glyph pixel renderer: beat types, configuration
// struct, register indexes, glyph and palette tables, colour packing.
// No dependencies; every other design file takes items from here by scoped name.
`default_nettype none

package tgr_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_DISPLAY_ENABLE = 3'd0;
  localparam logic [2:0] CFG_LINE_PITCH     = 3'd1;
  localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_SCREEN_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_BITS_PER_PIXEL = 3'd4;
  localparam logic [2:0] CFG_RED_LAYOUT     = 3'd5;
  localparam logic [2:0] CFG_GREEN_LAYOUT   = 3'd6;
  localparam logic [2:0] CFG_BLUE_LAYOUT    = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Supported colour depths
  localparam logic [5:0] BPP_15 = 6'd15;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  // Character codes with their own glyphs
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;
  localparam logic [7:0] CHAR_UNDER   = 8'h5f;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CASE_FOLD    = 8'd32;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Input beat
  typedef struct packed {
    logic [10:0] cell_column;
    logic [10:0] cell_row;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
  } cell_req_t;

  // Result beat
  typedef struct packed {
    logic [29:0] byte_offset;
    logic [31:0] pixel_value;
    logic [2:0]  byte_count;
    logic        last_pixel;
  } pixel_t;

  // Register file contents
  typedef struct packed {
    logic        display_enable;
    logic [15:0] line_pitch;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [5:0]  bits_per_pixel;
    logic [8:0]  red_layout;
    logic [8:0]  green_layout;
    logic [8:0]  blue_layout;
  } cfg_t;

  // Eight glyph rows of five bits, top row at index 0; row 7 is always blank
  typedef logic [7:0][4:0] glyph_t;

  // Classified cell as handed from front to back
  typedef struct packed {
    logic [29:0] base_offset;
    logic [31:0] fg_value;
    logic [31:0] bg_value;
    logic [2:0]  byte_count;
    glyph_t      glyph;
  } cell_job_t;

  // Glyph words: top row in the upper five bits
  localparam logic [34:0] LETTER_ROM [26] = '{
    {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14},
    {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
  };

  localparam logic [34:0] DIGIT_ROM [10] = '{
    {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
  };

  // Palette entries as {red, green, blue}
  localparam logic [23:0] PALETTE [16] = '{
    {8'd0,   8'd0,   8'd0},   {8'd0,   8'd0,   8'd170},
    {8'd0,   8'd170, 8'd0},   {8'd0,   8'd170, 8'd170},
    {8'd170, 8'd0,   8'd0},   {8'd170, 8'd0,   8'd170},
    {8'd170, 8'd85,  8'd0},   {8'd170, 8'd170, 8'd170},
    {8'd85,  8'd85,  8'd85},  {8'd85,  8'd85,  8'd255},
    {8'd85,  8'd255, 8'd85},  {8'd85,  8'd255, 8'd255},
    {8'd255, 8'd85,  8'd85},  {8'd255, 8'd85,  8'd255},
    {8'd255, 8'd255, 8'd85},  {8'd255, 8'd255, 8'd255}
  };

  // Glyph for a character code; unknown codes come back blank
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0]  c;
    logic [34:0] w;
    glyph_t      g;
    c = code;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - CASE_FOLD;
    end
    w = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      w = LETTER_ROM[5'(c - CHAR_UPPER_A)];
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      w = DIGIT_ROM[4'(c - CHAR_ZERO)];
    end else if (c == CHAR_DASH) begin
      w = {5'd0, 5'd0, 5'd0, 5'd31, 5'd31, 5'd0, 5'd0};
    end else if (c == CHAR_UNDER) begin
      w = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
    end else if (c == CHAR_DOT) begin
      w = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4};
    end else if (c == CHAR_COLON) begin
      w = {5'd0, 5'd0, 5'd4, 5'd0, 5'd0, 5'd4, 5'd0};
    end else if (c == CHAR_SLASH) begin
      w = {5'd0, 5'd2, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0};
    end
    g = '0;
    for (int i = 0; i < 7; i++) begin
      g[i] = w[34 - 5 * i -: 5];
    end
    return g;
  endfunction

  // One channel at its position; narrow depths first drop to the channel size
  function automatic logic [31:0] pack_channel(input logic [7:0] level,
                                               input logic [8:0] layout,
                                               input logic       narrow);
    logic [3:0] size;
    logic [7:0] lvl;
    size = (layout[3:0] > 4'd8) ? 4'd8 : layout[3:0];
    lvl  = narrow ? (level >> (4'd8 - size)) : level;
    return 32'(lvl) << layout[8:4];
  endfunction

  // Packed colour of a palette index
  function automatic logic [31:0] colour_of(input logic [3:0] index,
                                            input logic       narrow,
                                            input cfg_t       cfg);
    logic [23:0] rgb;
    rgb = PALETTE[index];
    return pack_channel(rgb[23:16], cfg.red_layout, narrow) |
           pack_channel(rgb[15:8], cfg.green_layout, narrow) |
           pack_channel(rgb[7:0], cfg.blue_layout, narrow);
  endfunction

endpackage

`default_nettype wire

@@ design/text_glyph_pixel_renderer.sv @@
// Top level of the text glyph pixel renderer: register file, front end,
// cell queue and pixel back end. Uses tgr_pkg, tgr_front, tgr_queue, tgr_back.
//
// Usage:
//   Cell requests arrive on cell_i and are taken at a rising edge where start
//   is high and busy is low. A cell that is off screen, or arrives while the
//   display is disabled or the depth is unsupported, is taken and dropped.
//   Every other cell produces 64 pixel beats on pixel_o, marked by
//   pixel_valid_o for one cycle each, top row first and left to right, with
//   last_pixel on the 64th. On its way to the ports a cell passes the front
//   stage register, the queue, the back end's job register and its pixel
//   register. Throughput is one pixel per cycle, set by the back end's pixel
//   walker; a queued cell follows the last one without a gap. The front
//   end and a two-entry queue hold up to three further cells, so busy only
//   rises when those are all full.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i by
//   the user only while no cell is in flight; the block does not enforce it.
//   Reset clears the registers to their defaults (display off, 32 bpp,
//   8x8 screen) and empties the pipeline. The receiver cannot stall beats.
`default_nettype none

module text_glyph_pixel_renderer (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire [tgr_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [tgr_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  wire                                   start,
  output logic                                  busy,
  input  tgr_pkg::cell_req_t                    cell_i,
  output logic                                  pixel_valid_o,
  output tgr_pkg::pixel_t                       pixel_o
);

  tgr_pkg::cfg_t      cfg_q;
  tgr_pkg::cfg_t      cfg_d;
  logic               accept;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  tgr_pkg::cell_job_t push_job;
  tgr_pkg::cell_job_t pop_job;

  assign accept = start && !busy;

  // Register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgr_pkg::CFG_DISPLAY_ENABLE: cfg_d.display_enable = cfg_wdata_i[0];
        tgr_pkg::CFG_LINE_PITCH:     cfg_d.line_pitch     = cfg_wdata_i;
        tgr_pkg::CFG_SCREEN_WIDTH:   cfg_d.screen_width   = cfg_wdata_i[13:0];
        tgr_pkg::CFG_SCREEN_HEIGHT:  cfg_d.screen_height  = cfg_wdata_i[13:0];
        tgr_pkg::CFG_BITS_PER_PIXEL: cfg_d.bits_per_pixel = cfg_wdata_i[5:0];
        tgr_pkg::CFG_RED_LAYOUT:     cfg_d.red_layout     = cfg_wdata_i[8:0];
        tgr_pkg::CFG_GREEN_LAYOUT:   cfg_d.green_layout   = cfg_wdata_i[8:0];
        tgr_pkg::CFG_BLUE_LAYOUT:    cfg_d.blue_layout    = cfg_wdata_i[8:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_enable <= 1'b0;
      cfg_q.line_pitch     <= '0;
      cfg_q.screen_width   <= 14'd8;
      cfg_q.screen_height  <= 14'd8;
      cfg_q.bits_per_pixel <= tgr_pkg::BPP_32;
      cfg_q.red_layout     <= '0;
      cfg_q.green_layout   <= '0;
      cfg_q.blue_layout    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .cell_i   (cell_i),
    .busy_o   (busy),
    .push_o   (push),
    .job_o    (push_job),
    .q_full_i (q_full)
  );

  tgr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  tgr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_pitch_i  (cfg_q.line_pitch),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_job),
    .pop_o         (pop),
    .pixel_valid_o (pixel_valid_o),
    .pixel_o       (pixel_o)
  );

`ifndef NO_ASSERTIONS
  // A cell's 64 beats come out without a gap
  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && !pixel_o.last_pixel |=> pixel_valid_o)
    else $error("gap inside a cell's pixel beats");

  // Byte count stays fixed across one cell
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && !pixel_o.last_pixel |=> $stable(pixel_o.byte_count))
    else $error("byte count changed inside a cell");

  // Busy is only raised with the queue full
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> q_full && !push)
    else $error("busy without a full queue");
`endif

endmodule

`default_nettype wire

@@ design/tgr_front.sv @@
// Front end: takes cell requests, drops those that give no output, looks up
// glyph and colours, then works out the cell's base byte offset. Uses tgr_pkg.
`default_nettype none

module tgr_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tgr_pkg::cfg_t        cfg_i,
  input  wire                  accept_i,
  input  tgr_pkg::cell_req_t   cell_i,
  output logic                 busy_o,
  output logic                 push_o,
  output tgr_pkg::cell_job_t   job_o,
  input  wire                  q_full_i
);

  typedef struct packed {
    logic [10:0]     cell_column;
    logic [10:0]     cell_row;
    logic [31:0]     fg_value;
    logic [31:0]     bg_value;
    logic [2:0]      byte_count;
    tgr_pkg::glyph_t glyph;
  } stage_t;

  logic        in_ok;
  logic        bpp_ok;
  logic        narrow;
  logic [2:0]  nbytes;
  logic [31:0] vmask;
  stage_t      stage_d, stage_q;
  logic        stage_valid_d, stage_valid_q;

  // Depth decode
  always_comb begin
    bpp_ok = 1'b1;
    narrow = 1'b0;
    nbytes = 3'd4;
    vmask  = 32'hFFFF_FFFF;
    unique case (cfg_i.bits_per_pixel)
      tgr_pkg::BPP_15, tgr_pkg::BPP_16: begin
        narrow = 1'b1;
        nbytes = 3'd2;
        vmask  = 32'h0000_FFFF;
      end
      tgr_pkg::BPP_24: begin
        nbytes = 3'd3;
        vmask  = 32'h00FF_FFFF;
      end
      tgr_pkg::BPP_32: begin
        nbytes = 3'd4;
      end
      default: bpp_ok = 1'b0;
    endcase
  end

  // Classify and look up the cell
  always_comb begin
    in_ok = cfg_i.display_enable && bpp_ok &&
            (cell_i.cell_column < cfg_i.screen_width[13:3]) &&
            (cell_i.cell_row < cfg_i.screen_height[13:3]);
    stage_d.cell_column = cell_i.cell_column;
    stage_d.cell_row    = cell_i.cell_row;
    stage_d.byte_count  = nbytes;
    stage_d.glyph       = tgr_pkg::glyph_lookup(cell_i.char_code);
    stage_d.fg_value    = tgr_pkg::colour_of(cell_i.attribute[3:0], narrow, cfg_i) & vmask;
    stage_d.bg_value    = tgr_pkg::colour_of(cell_i.attribute[7:4], narrow, cfg_i) & vmask;
  end

  // Hand-off to the queue
  assign push_o = stage_valid_q && !q_full_i;
  assign busy_o = stage_valid_q && q_full_i;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept_i) begin
      stage_valid_d = in_ok;
    end else if (push_o) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  // Base offset: top-left pixel of the cell, wrapped to 30 bits
  always_comb begin
    job_o.base_offset = 30'(30'({stage_q.cell_row, 3'b000}) * 30'(cfg_i.line_pitch)) +
                        30'(30'({stage_q.cell_column, 3'b000}) * 30'(stage_q.byte_count));
    job_o.fg_value    = stage_q.fg_value;
    job_o.bg_value    = stage_q.bg_value;
    job_o.byte_count  = stage_q.byte_count;
    job_o.glyph       = stage_q.glyph;
  end

endmodule

`default_nettype wire

@@ design/tgr_queue.sv @@
// Short queue of classified cells between front and back ends.
// Uses tgr_pkg for the entry type and depth constants.
`default_nettype none

module tgr_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  tgr_pkg::cell_job_t   push_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output tgr_pkg::cell_job_t   pop_data_o
);

  tgr_pkg::cell_job_t                 mem_q [tgr_pkg::Q_DEPTH];
  logic [tgr_pkg::Q_PTR_W-1:0]        wr_ptr_d, wr_ptr_q;
  logic [tgr_pkg::Q_PTR_W-1:0]        rd_ptr_d, rd_ptr_q;
  logic [tgr_pkg::Q_CNT_W-1:0]        count_d, count_q;
  logic                               do_push, do_pop;

  assign full_o     = (count_q == tgr_pkg::Q_CNT_W'(tgr_pkg::Q_DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/tgr_back.sv @@
// Back end: expands one queued cell into 64 pixel beats, one per cycle,
// row by row. Uses tgr_pkg for the job and pixel types.
`default_nettype none

module tgr_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [15:0]           line_pitch_i,
  input  wire                  q_valid_i,
  input  tgr_pkg::cell_job_t   q_data_i,
  output logic                 pop_o,
  output logic                 pixel_valid_o,
  output tgr_pkg::pixel_t      pixel_o
);

  tgr_pkg::cell_job_t job_q;
  logic               active_d, active_q;
  logic [5:0]         cnt_d, cnt_q;
  logic [29:0]        row_off_d, row_off_q;
  logic [4:0]         col_off_d, col_off_q;
  logic               strobe_d, strobe_q;
  tgr_pkg::pixel_t    pixel_d, pixel_q;
  logic [2:0]         px;
  logic [2:0]         py;
  logic [7:0]         row_bits;
  logic               pix_on;

  assign px = cnt_q[2:0];
  assign py = cnt_q[5:3];

  // Next cell is taken while the last beat of the current one is being registered
  assign pop_o = q_valid_i && (!active_q || cnt_q == 6'd63);

  // Glyph bit for this pixel: columns 1..5 map to bits 4..0, others read zero
  always_comb begin
    row_bits = {3'b000, job_q.glyph[py]};
    pix_on   = row_bits[3'(3'd5 - px)];
  end

  // Beat generation and walk through the cell
  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    row_off_d = row_off_q;
    col_off_d = col_off_q;
    strobe_d  = active_q;
    pixel_d.byte_offset = row_off_q + 30'(col_off_q);
    pixel_d.pixel_value = pix_on ? job_q.fg_value : job_q.bg_value;
    pixel_d.byte_count  = job_q.byte_count;
    pixel_d.last_pixel  = (cnt_q == 6'd63);
    if (active_q) begin
      cnt_d = cnt_q + 6'd1;
      if (px == 3'd7) begin
        row_off_d = row_off_q + 30'(line_pitch_i);
        col_off_d = '0;
      end else begin
        col_off_d = col_off_q + 5'(job_q.byte_count);
      end
      if (cnt_q == 6'd63) begin
        active_d = 1'b0;
      end
    end
    if (pop_o) begin
      active_d  = 1'b1;
      cnt_d     = '0;
      row_off_d = q_data_i.base_offset;
      col_off_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_off_q <= row_off_d;
    col_off_q <= col_off_d;
    pixel_q   <= pixel_d;
    if (pop_o) begin
      job_q <= q_data_i;
    end
  end

  assign pixel_valid_o = strobe_q;
  assign pixel_o       = pixel_q;

endmodule

`default_nettype wire
